// ===== design/phf_pkg.sv =====
// phf_pkg: shared types, constants and codes for the packet header filter
// used by every module of the block; no dependencies

package phf_pkg;

    // byte counter width, count saturates at all ones
    localparam int LENGTH_BITS = 16;
    localparam logic [LENGTH_BITS-1:0] COUNT_MAX = {LENGTH_BITS{1'b1}};

    // header length field and needed-length width
    localparam int HDR_W  = 16;
    localparam int NEED_W = 6;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_MATCH_ADDRESS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MATCH_PORT    = 2'd1;

    // protocol constants
    localparam logic [15:0] ETYPE_IPV4  = 16'h0800;
    localparam logic [15:0] ETYPE_IPV6  = 16'h86DD;
    localparam logic [15:0] ETYPE_ARP   = 16'h0806;
    localparam logic [7:0]  PROTO_TCP   = 8'd6;
    localparam logic [7:0]  PROTO_UDP   = 8'd17;
    localparam logic [15:0] ARP_REQUEST = 16'd1;
    localparam logic [15:0] ARP_REPLY   = 16'd2;
    localparam logic [7:0]  ARP_IP_LEN  = 8'd4;
    localparam logic [3:0]  IP_V4       = 4'd4;

    // packet kind codes
    localparam logic [2:0] KIND_OTHER    = 3'd0;
    localparam logic [2:0] KIND_TCP      = 3'd1;
    localparam logic [2:0] KIND_UDP      = 3'd2;
    localparam logic [2:0] KIND_IP_OTHER = 3'd3;
    localparam logic [2:0] KIND_NOT_V4   = 3'd4;
    localparam logic [2:0] KIND_ARP      = 3'd5;

    // expected header lengths
    localparam logic [NEED_W-1:0] NEED_ETH      = 6'd14;
    localparam logic [NEED_W-1:0] NEED_IP       = 6'd34;
    localparam logic [NEED_W-1:0] NEED_UDP      = 6'd42;
    localparam logic [NEED_W-1:0] NEED_TCP      = 6'd54;
    localparam logic [NEED_W-1:0] NEED_ARP_BASE = 6'd22;
    localparam logic [NEED_W-1:0] NEED_ARP_FULL = 6'd42;

    // input word
    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_frame;
    } in_word_t;

    // result word
    typedef struct packed {
        logic             matched;
        logic [2:0]       packet_kind;
        logic [HDR_W-1:0] header_bytes;
        logic             truncated;
    } out_word_t;

    // per-frame summary handed from front to back
    typedef struct packed {
        logic [2:0]             kind;
        logic [NEED_W-1:0]      need;
        logic [LENGTH_BITS-1:0] len;
        logic                   no_push_syn;
        logic                   arp_full;
        logic [31:0]            first_address;
        logic [31:0]            second_address;
        logic [15:0]            first_port;
        logic [15:0]            second_port;
    } frame_sum_t;

    // filter settings
    typedef struct packed {
        logic [31:0] match_address;
        logic [15:0] match_port;
    } cfg_t;

    // queue status toward the front
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

// ===== design/phf_front.sv =====
// phf_front: byte-serial header capture and frame classification
// depends on phf_pkg; pushes one summary per frame into the queue

module phf_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  phf_pkg::in_word_t s_data,
    input  phf_pkg::q_status_t q_status,
    output logic              sum_push,
    output phf_pkg::frame_sum_t sum_data
);
    import phf_pkg::*;

    logic [LENGTH_BITS-1:0] pos_reg;
    logic [15:0] etype_reg, etype_next;
    logic [3:0]  ver_reg, ver_next;
    logic [7:0]  proto_reg, proto_next;
    logic [31:0] addr1_reg, addr1_next;
    logic [31:0] addr2_reg, addr2_next;
    logic [15:0] port1_reg, port1_next;
    logic [15:0] port2_reg, port2_next;
    logic [1:0]  psh_syn_reg, psh_syn_next;
    logic [15:0] arp_op_reg, arp_op_next;
    logic [7:0]  arp_plen_reg, arp_plen_next;

    logic [LENGTH_BITS-1:0] len;
    logic [5:0] cap_pos;
    logic       in_window;
    logic       accept;
    logic       cur_is_ip;
    logic       next_is_ip;
    logic [7:0] b;

    assign s_ready  = !q_status.full;
    assign accept   = s_valid && s_ready;
    assign sum_push = accept && s_data.end_of_frame;
    assign b        = s_data.data_byte;

    assign cap_pos   = pos_reg[5:0];
    assign in_window = (pos_reg[LENGTH_BITS-1:6] == '0);
    assign len       = (pos_reg == COUNT_MAX) ? COUNT_MAX : pos_reg + 1'b1;
    assign cur_is_ip = (etype_reg == ETYPE_IPV4) || (etype_reg == ETYPE_IPV6);

    // field capture by byte offset
    always_comb begin
        etype_next    = etype_reg;
        ver_next      = ver_reg;
        proto_next    = proto_reg;
        addr1_next    = addr1_reg;
        addr2_next    = addr2_reg;
        port1_next    = port1_reg;
        port2_next    = port2_reg;
        psh_syn_next  = psh_syn_reg;
        arp_op_next   = arp_op_reg;
        arp_plen_next = arp_plen_reg;
        if (in_window) begin
            if (cap_pos == 6'd12) begin
                etype_next = {b, etype_reg[7:0]};
            end else if (cap_pos == 6'd13) begin
                etype_next = {etype_reg[15:8], b};
            end else if (cur_is_ip) begin
                if (cap_pos == 6'd14) begin
                    ver_next = b[7:4];
                end else if (cap_pos == 6'd23) begin
                    proto_next = b;
                end else if (cap_pos inside {[6'd26:6'd29]}) begin
                    addr1_next = {addr1_reg[23:0], b};
                end else if (cap_pos inside {[6'd30:6'd33]}) begin
                    addr2_next = {addr2_reg[23:0], b};
                end else if (cap_pos inside {6'd34, 6'd35}) begin
                    port1_next = {port1_reg[7:0], b};
                end else if (cap_pos inside {6'd36, 6'd37}) begin
                    port2_next = {port2_reg[7:0], b};
                end else if (cap_pos == 6'd47) begin
                    psh_syn_next = {b[3], b[1]};
                end
            end else if (etype_reg == ETYPE_ARP) begin
                if (cap_pos == 6'd19) begin
                    arp_plen_next = b;
                end else if (cap_pos inside {6'd20, 6'd21}) begin
                    arp_op_next = {arp_op_reg[7:0], b};
                end else if (cap_pos inside {[6'd28:6'd31]}) begin
                    addr1_next = {addr1_reg[23:0], b};
                end else if (cap_pos inside {[6'd38:6'd41]}) begin
                    addr2_next = {addr2_reg[23:0], b};
                end
            end
        end
    end

    assign next_is_ip = (etype_next == ETYPE_IPV4) || (etype_next == ETYPE_IPV6);

    // classify the frame from the values after this word
    always_comb begin
        sum_data                = '0;
        sum_data.len            = len;
        sum_data.no_push_syn    = (psh_syn_next == 2'b00);
        sum_data.arp_full       = ((arp_op_next == ARP_REQUEST) || (arp_op_next == ARP_REPLY))
                                  && (arp_plen_next == ARP_IP_LEN);
        sum_data.first_address  = addr1_next;
        sum_data.second_address = addr2_next;
        sum_data.first_port     = port1_next;
        sum_data.second_port    = port2_next;
        if (next_is_ip) begin
            if (ver_next == IP_V4) begin
                if (proto_next == PROTO_TCP) begin
                    sum_data.kind = KIND_TCP;
                    sum_data.need = NEED_TCP;
                end else if (proto_next == PROTO_UDP) begin
                    sum_data.kind = KIND_UDP;
                    sum_data.need = NEED_UDP;
                end else begin
                    sum_data.kind = KIND_IP_OTHER;
                    sum_data.need = NEED_IP;
                end
            end else begin
                sum_data.kind = KIND_NOT_V4;
                sum_data.need = NEED_ETH;
            end
        end else if (etype_next == ETYPE_ARP) begin
            sum_data.kind = KIND_ARP;
            sum_data.need = sum_data.arp_full ? NEED_ARP_FULL : NEED_ARP_BASE;
        end else begin
            sum_data.kind = KIND_OTHER;
            sum_data.need = NEED_ETH;
        end
    end

    // frame state, cleared after the last word
    always_ff @(posedge aclk) begin
        if (!aresetn || sum_push) begin
            pos_reg      <= '0;
            etype_reg    <= '0;
            ver_reg      <= '0;
            proto_reg    <= '0;
            addr1_reg    <= '0;
            addr2_reg    <= '0;
            port1_reg    <= '0;
            port2_reg    <= '0;
            psh_syn_reg  <= '0;
            arp_op_reg   <= '0;
            arp_plen_reg <= '0;
        end else if (accept) begin
            pos_reg      <= len;
            etype_reg    <= etype_next;
            ver_reg      <= ver_next;
            proto_reg    <= proto_next;
            addr1_reg    <= addr1_next;
            addr2_reg    <= addr2_next;
            port1_reg    <= port1_next;
            port2_reg    <= port2_next;
            psh_syn_reg  <= psh_syn_next;
            arp_op_reg   <= arp_op_next;
            arp_plen_reg <= arp_plen_next;
        end
    end

endmodule

// ===== design/phf_queue.sv =====
// phf_queue: two-entry queue of frame summaries between front and back
// depends on phf_pkg

module phf_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  phf_pkg::frame_sum_t push_data,
    input  logic                pop,
    output phf_pkg::frame_sum_t head_data,
    output phf_pkg::q_status_t  status
);
    import phf_pkg::*;

    frame_sum_t mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       do_push;
    logic       do_pop;

    assign status.full  = (count_reg == 2'd2);
    assign status.empty = (count_reg == 2'd0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head_data    = mem_reg[rd_ptr_reg];

    // entry storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 2'd1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

// ===== design/phf_back.sv =====
// phf_back: length, truncation and filter decision, output register
// depends on phf_pkg; takes summaries from phf_queue

module phf_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  phf_pkg::cfg_t       cfg,
    input  phf_pkg::frame_sum_t head_data,
    input  phf_pkg::q_status_t  q_status,
    output logic                pop,
    output logic                m_valid,
    input  logic                m_ready,
    output phf_pkg::out_word_t  m_data
);
    import phf_pkg::*;

    logic                   m_valid_reg;
    out_word_t              m_data_reg;
    out_word_t              result;
    logic [LENGTH_BITS-1:0] need_ext;
    logic                   trunc;
    logic                   addr_ok;
    logic                   port_ok;

    assign pop      = !q_status.empty && (!m_valid_reg || m_ready);
    assign need_ext = LENGTH_BITS'(head_data.need);
    assign trunc    = head_data.len < need_ext;

    assign addr_ok = (cfg.match_address == 32'd0)
                     || (cfg.match_address == head_data.first_address)
                     || (cfg.match_address == head_data.second_address);
    assign port_ok = (cfg.match_port == 16'd0)
                     || (cfg.match_port == head_data.first_port)
                     || (cfg.match_port == head_data.second_port);

    // result fields
    always_comb begin
        result.packet_kind = head_data.kind;
        result.truncated   = trunc;
        if (trunc || (head_data.kind == KIND_ARP)
                  || ((head_data.kind == KIND_TCP) && head_data.no_push_syn)) begin
            result.header_bytes = HDR_W'(head_data.len);
        end else begin
            result.header_bytes = HDR_W'(head_data.need);
        end
        if (trunc) begin
            result.matched = 1'b0;
        end else begin
            case (head_data.kind)
                KIND_TCP, KIND_UDP: result.matched = addr_ok && port_ok;
                KIND_ARP:           result.matched = head_data.arp_full && addr_ok;
                default:            result.matched = 1'b0;
            endcase
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (pop) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            m_data_reg <= result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== design/packet_header_filter.sv =====
// packet_header_filter: top level with filter settings and the front/queue/back
// depends on phf_pkg, phf_front, phf_queue, phf_back
//
// Usage:
// - s_ channel carries one frame byte per word, starting at the destination
//   MAC, with end_of_frame on the final byte. One word per cycle while s_ready.
// - m_ channel gives one result word per frame: matched, packet_kind,
//   header_bytes and truncated. Non-final bytes give no result.
// - The summary is queued when the final byte is taken; the decision loads
//   the output register when that summary is popped from the queue.
// - Throughput: one byte per cycle while s_ready is high, one result per
//   cycle while the receiver is ready; the two-entry summary queue and the
//   output register set the slack toward the receiver.
// - When the receiver stalls, finished frames collect in the queue; s_ready
//   drops only while the queue holds two frames.
// - cfg_wr_en/cfg_index/cfg_wdata write match_address (0) and match_port (1),
//   zero meaning any; other indexes are ignored. The settings are read when
//   the frame's result is formed.
// - Reset clears the settings, the frame capture state and the queue.

module packet_header_filter (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  phf_pkg::in_word_t                   s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output phf_pkg::out_word_t                  m_data,
    input  logic                                cfg_wr_en,
    input  logic [phf_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [phf_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
    import phf_pkg::*;

    cfg_t       cfg_reg;
    frame_sum_t push_data;
    frame_sum_t head_data;
    q_status_t  q_status;
    logic       sum_push;
    logic       sum_pop;

    // filter settings
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_MATCH_ADDRESS: cfg_reg.match_address <= cfg_wdata;
                CFG_MATCH_PORT:    cfg_reg.match_port    <= cfg_wdata[15:0];
                default:           cfg_reg               <= cfg_reg;
            endcase
        end
    end

    phf_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .q_status (q_status),
        .sum_push (sum_push),
        .sum_data (push_data)
    );

    phf_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (sum_push),
        .push_data (push_data),
        .pop       (sum_pop),
        .head_data (head_data),
        .status    (q_status)
    );

    phf_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .head_data (head_data),
        .q_status  (q_status),
        .pop       (sum_pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

`ifndef SYNTHESIS
    // a frame summary is never pushed into a full queue
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        sum_push |-> !q_status.full)
        else $error("summary pushed into full queue");

    // a truncated frame never passes the filter
    a_trunc_no_match: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_data.truncated && m_data.matched))
        else $error("truncated frame marked as matched");

    // a new result only appears after the queue held a summary
    a_result_from_queue: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!q_status.empty))
        else $error("result without queued summary");

    // a matching arp frame always carries the full address part
    a_arp_match_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.matched && (m_data.packet_kind == KIND_ARP))
            |-> (m_data.header_bytes >= 16'd42))
        else $error("arp match with short header");
`endif

endmodule
